@@ sv/tlms_pkg.sv @@
// ---------------------------------------------------------------------------
// tlms_pkg
// Shared types, constants and step tables for the traffic lamp mode
// sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package tlms_pkg;

  // Width of the elapsed-time counter in milliseconds.
  localparam int TIME_WIDTH = 20;
  // Width of each duration register.
  localparam int CFG_W      = 20;
  // Width used for comparing the counter against a duration.
  localparam int CMP_W      = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;
  // Register file geometry on the APB port.
  localparam int NUM_REGS   = 6;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  typedef logic [CFG_W-1:0]      dur_t;
  typedef logic [TIME_WIDTH-1:0] elapsed_t;
  typedef logic [CMP_W-1:0]      cmp_t;
  typedef logic [2:0]            mode_t;
  typedef logic [1:0]            step_t;

  // Input beat kinds.
  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_SET  = 2'd1,
    ACT_NEXT = 2'd2,
    ACT_IDLE = 2'd3
  } action_t;

  // Duration selector; the first six codes double as register indexes.
  typedef enum logic [2:0] {
    SEL_RED        = 3'd0,
    SEL_GREEN      = 3'd1,
    SEL_ORANGE     = 3'd2,
    SEL_RED_ORANGE = 3'd3,
    SEL_BLINK      = 3'd4,
    SEL_CHASE      = 3'd5,
    SEL_NONE       = 3'd6
  } dur_sel_t;

  // Mode numbers.
  localparam mode_t MODE_FRUS   = 3'd0;
  localparam mode_t MODE_UK     = 3'd1;
  localparam mode_t MODE_BLINK  = 3'd2;
  localparam mode_t MODE_RED    = 3'd3;
  localparam mode_t MODE_ORANGE = 3'd4;
  localparam mode_t MODE_GREEN  = 3'd5;
  localparam mode_t MODE_ALL    = 3'd6;
  localparam mode_t MODE_SWEEP  = 3'd7;

  // Duration register reset values.
  localparam dur_t RED_TIME_RST        = CFG_W'(5000);
  localparam dur_t GREEN_TIME_RST      = CFG_W'(5000);
  localparam dur_t ORANGE_TIME_RST     = CFG_W'(2000);
  localparam dur_t RED_ORANGE_TIME_RST = CFG_W'(1000);
  localparam dur_t BLINK_TIME_RST      = CFG_W'(500);
  localparam dur_t CHASE_TIME_RST      = CFG_W'(300);

  // All duration registers, as seen by the step logic.
  typedef struct packed {
    dur_t red_time;
    dur_t green_time;
    dur_t orange_time;
    dur_t red_orange_time;
    dur_t blink_time;
    dur_t chase_time;
  } cfg_t;

  typedef struct packed {
    logic red;
    logic orange;
    logic green;
  } lamps_t;

  typedef struct packed {
    lamps_t   lamps;
    dur_sel_t sel;
  } step_info_t;

  localparam lamps_t LAMP_OFF = 3'b000;
  localparam lamps_t LAMP_R   = 3'b100;
  localparam lamps_t LAMP_O   = 3'b010;
  localparam lamps_t LAMP_G   = 3'b001;
  localparam lamps_t LAMP_RO  = 3'b110;
  localparam lamps_t LAMP_ALL = 3'b111;

  // Last step index of each mode; steps wrap after it.
  function automatic step_t last_step(mode_t m);
    step_t r;
    case (m)
      MODE_FRUS:  r = 2'd2;
      MODE_UK:    r = 2'd3;
      MODE_BLINK: r = 2'd1;
      MODE_SWEEP: r = 2'd3;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction

  // Lamp pattern and duration selector of one step of one mode.
  function automatic step_info_t step_info(mode_t m, step_t s);
    step_info_t r;
    r = '{lamps: LAMP_OFF, sel: SEL_NONE};
    case (m)
      MODE_FRUS: begin
        case (s)
          2'd0:    r = '{lamps: LAMP_R, sel: SEL_RED};
          2'd1:    r = '{lamps: LAMP_G, sel: SEL_GREEN};
          2'd2:    r = '{lamps: LAMP_O, sel: SEL_ORANGE};
          default: r = '{lamps: LAMP_OFF, sel: SEL_NONE};
        endcase
      end
      MODE_UK: begin
        case (s)
          2'd0:    r = '{lamps: LAMP_R,  sel: SEL_RED};
          2'd1:    r = '{lamps: LAMP_RO, sel: SEL_RED_ORANGE};
          2'd2:    r = '{lamps: LAMP_G,  sel: SEL_GREEN};
          default: r = '{lamps: LAMP_O,  sel: SEL_ORANGE};
        endcase
      end
      MODE_BLINK: begin
        case (s)
          2'd0:    r = '{lamps: LAMP_O,   sel: SEL_BLINK};
          2'd1:    r = '{lamps: LAMP_OFF, sel: SEL_BLINK};
          default: r = '{lamps: LAMP_OFF, sel: SEL_NONE};
        endcase
      end
      MODE_RED:    r = '{lamps: (s == 2'd0) ? LAMP_R   : LAMP_OFF, sel: SEL_NONE};
      MODE_ORANGE: r = '{lamps: (s == 2'd0) ? LAMP_O   : LAMP_OFF, sel: SEL_NONE};
      MODE_GREEN:  r = '{lamps: (s == 2'd0) ? LAMP_G   : LAMP_OFF, sel: SEL_NONE};
      MODE_ALL:    r = '{lamps: (s == 2'd0) ? LAMP_ALL : LAMP_OFF, sel: SEL_NONE};
      default: begin
        case (s)
          2'd0:    r = '{lamps: LAMP_R, sel: SEL_CHASE};
          2'd1:    r = '{lamps: LAMP_O, sel: SEL_CHASE};
          2'd2:    r = '{lamps: LAMP_G, sel: SEL_CHASE};
          default: r = '{lamps: LAMP_O, sel: SEL_CHASE};
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/tlms_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// tlms_cfg_regs
// APB register file holding the six step durations.
// ---------------------------------------------------------------------------
`default_nettype none

module tlms_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tlms_pkg::ADDR_W-1:0]  paddr,
  input  logic [tlms_pkg::DATA_W-1:0]  pwdata,
  output logic [tlms_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output tlms_pkg::cfg_t               cfg
);
  import tlms_pkg::*;

  logic     wr_en;
  dur_sel_t idx;
  dur_t     wdata;
  dur_t     rdata;

  // Registers are word aligned; the low address bits are ignored.
  assign idx    = dur_sel_t'(paddr[ADDR_W-1:2]);
  assign wdata  = pwdata[CFG_W-1:0];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes; an address beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.red_time        <= RED_TIME_RST;
      cfg.green_time      <= GREEN_TIME_RST;
      cfg.orange_time     <= ORANGE_TIME_RST;
      cfg.red_orange_time <= RED_ORANGE_TIME_RST;
      cfg.blink_time      <= BLINK_TIME_RST;
      cfg.chase_time      <= CHASE_TIME_RST;
    end else if (wr_en) begin
      case (idx)
        SEL_RED:        cfg.red_time        <= wdata;
        SEL_GREEN:      cfg.green_time      <= wdata;
        SEL_ORANGE:     cfg.orange_time     <= wdata;
        SEL_RED_ORANGE: cfg.red_orange_time <= wdata;
        SEL_BLINK:      cfg.blink_time      <= wdata;
        SEL_CHASE:      cfg.chase_time      <= wdata;
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (idx)
      SEL_RED:        rdata = cfg.red_time;
      SEL_GREEN:      rdata = cfg.green_time;
      SEL_ORANGE:     rdata = cfg.orange_time;
      SEL_RED_ORANGE: rdata = cfg.red_orange_time;
      SEL_BLINK:      rdata = cfg.blink_time;
      SEL_CHASE:      rdata = cfg.chase_time;
      default:        rdata = '0;
    endcase
  end

  assign prdata = DATA_W'(rdata);

endmodule

`default_nettype wire

@@ sv/tlms_step_unit.sv @@
// ---------------------------------------------------------------------------
// tlms_step_unit
// Input register, mode/step/elapsed state update and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module tlms_step_unit (
  input  logic             clk,
  input  logic             rst,
  input  tlms_pkg::cfg_t   cfg,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       action,
  input  logic [3:0]       mode_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             red_on,
  output logic             orange_on,
  output logic             green_on,
  output tlms_pkg::mode_t  mode_now,
  output tlms_pkg::step_t  step_now
);
  import tlms_pkg::*;

  // Input stage.
  logic       s1_valid;
  action_t    s1_action;
  logic [3:0] s1_mode_value;
  logic       advance;

  // Sequencer state.
  mode_t      mode_reg;
  mode_t      mode_reg_next;
  step_t      step_reg;
  step_t      step_reg_next;
  elapsed_t   elapsed;
  elapsed_t   elapsed_next;

  step_info_t cur_info;
  step_info_t new_info;
  elapsed_t   elapsed_inc;
  dur_t       dur;
  logic       step_done;

  // The result register moves whenever it is empty or being taken.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_action     <= action_t'(action);
      s1_mode_value <= mode_value;
    end
  end

  // Duration of the current step.
  assign cur_info = step_info(mode_reg, step_reg);

  always_comb begin
    case (cur_info.sel)
      SEL_RED:        dur = cfg.red_time;
      SEL_GREEN:      dur = cfg.green_time;
      SEL_ORANGE:     dur = cfg.orange_time;
      SEL_RED_ORANGE: dur = cfg.red_orange_time;
      SEL_BLINK:      dur = cfg.blink_time;
      SEL_CHASE:      dur = cfg.chase_time;
      default:        dur = '0;
    endcase
  end

  // Saturating millisecond count and end-of-step test.
  assign elapsed_inc = (elapsed == '1) ? elapsed : elapsed + 1'b1;
  assign step_done   = (dur != '0) && (CMP_W'(elapsed_inc) >= CMP_W'(dur));

  // Next state for the beat in the input stage.
  always_comb begin
    mode_reg_next = mode_reg;
    step_reg_next = step_reg;
    elapsed_next  = elapsed;
    case (s1_action)
      ACT_TICK: begin
        if (step_done) begin
          step_reg_next = (step_reg == last_step(mode_reg)) ? 2'd0 : step_reg + 2'd1;
          elapsed_next  = '0;
        end else begin
          elapsed_next  = elapsed_inc;
        end
      end
      ACT_SET: begin
        if (!s1_mode_value[3]) begin
          mode_reg_next = s1_mode_value[2:0];
          step_reg_next = '0;
          elapsed_next  = '0;
        end
      end
      ACT_NEXT: begin
        mode_reg_next = mode_reg + 3'd1;
        step_reg_next = '0;
        elapsed_next  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg <= MODE_FRUS;
      step_reg <= '0;
      elapsed  <= '0;
    end else if (advance && s1_valid) begin
      mode_reg <= mode_reg_next;
      step_reg <= step_reg_next;
      elapsed  <= elapsed_next;
    end
  end

  // Lamp pattern of the state after the beat.
  assign new_info = step_info(mode_reg_next, step_reg_next);

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      red_on    <= new_info.lamps.red;
      orange_on <= new_info.lamps.orange;
      green_on  <= new_info.lamps.green;
      mode_now  <= mode_reg_next;
      step_now  <= step_reg_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/traffic_light_mode_sequencer_unit.sv @@
// Flow: a beat goes from the input register to the result register, where it
// is taken. Throughput: one beat per cycle unless out_stall holds the result,
// set by the single input and result register pair around the step logic;
// any pattern of ticks and mode commands qualifies.
// Reset: synchronous; mode FR/US, step zero, elapsed count zero, durations at
// their defaults and both pipeline stages empty.
// ---------------------------------------------------------------------------
// traffic_light_mode_sequencer_unit
// Traffic lamp sequencer with eight fixed modes and APB duration registers.
// ---------------------------------------------------------------------------
`default_nettype none

module traffic_light_mode_sequencer_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tlms_pkg::ADDR_W-1:0]  paddr,
  input  logic [tlms_pkg::DATA_W-1:0]  pwdata,
  output logic [tlms_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   action,
  input  logic [3:0]                   mode_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         red_on,
  output logic                         orange_on,
  output logic                         green_on,
  output logic [2:0]                   mode_now,
  output logic [1:0]                   step_now
);
  import tlms_pkg::*;

  cfg_t       cfg;
  step_info_t out_info;

  // Duration registers.
  tlms_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer pipeline.
  tlms_step_unit u_step_unit (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .mode_value (mode_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red_on     (red_on),
    .orange_on  (orange_on),
    .green_on   (green_on),
    .mode_now   (mode_now),
    .step_now   (step_now)
  );

  assign out_info = step_info(mode_now, step_now);

  // The pipeline is empty straight after reset.
  a_empty_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  // The input side only stalls behind a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // A delivered step never lies beyond the mode's step count.
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (step_now <= last_step(mode_now)))
    else $error("step index beyond the mode's step count");

  // Lamps agree with the step table for the delivered mode and step.
  a_lamps_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({red_on, orange_on, green_on} == out_info.lamps))
    else $error("lamp outputs disagree with the step table");

endmodule

`default_nettype wire
